[rtl/isxu_pkg.sv]
// ----------------------------------------------------------------------------
// isxu_pkg
// Shared types, opcodes, status codes and defaults of the stack expression
// unit.
// ----------------------------------------------------------------------------
package isxu_pkg;

  localparam int STACK_DEPTH_MAX_DEF = 256;
  localparam int VALUE_WIDTH_DEF     = 32;

  localparam int KIND_W      = 5;
  localparam int OPERAND_W   = 32;
  localparam int TOP_W       = 32;
  localparam int DEPTH_OUT_W = 9;
  localparam int STATUS_W    = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t K_PUSH   = 5'd0;
  localparam kind_t K_RESET  = 5'd1;
  localparam kind_t K_CLRU   = 5'd2;
  localparam kind_t K_LNOT   = 5'd3;
  localparam kind_t K_BNOT   = 5'd4;
  localparam kind_t K_BOOL   = 5'd5;
  localparam kind_t K_LOR    = 5'd6;
  localparam kind_t K_LAND   = 5'd7;
  localparam kind_t K_BOR    = 5'd8;
  localparam kind_t K_XOR    = 5'd9;
  localparam kind_t K_BAND   = 5'd10;
  localparam kind_t K_NEG    = 5'd11;
  localparam kind_t K_EQ     = 5'd12;
  localparam kind_t K_NE     = 5'd13;
  localparam kind_t K_GT     = 5'd14;
  localparam kind_t K_LT     = 5'd15;
  localparam kind_t K_GE     = 5'd16;
  localparam kind_t K_LE     = 5'd17;
  localparam kind_t K_ADD    = 5'd18;
  localparam kind_t K_SUB    = 5'd19;
  localparam kind_t K_MUL    = 5'd20;
  localparam kind_t K_DIV    = 5'd21;
  localparam kind_t K_MOD    = 5'd22;
  localparam kind_t K_POW    = 5'd23;
  localparam kind_t K_JUMPZ  = 5'd24;
  localparam kind_t K_JUMPNZ = 5'd25;
  localparam kind_t K_JTERN  = 5'd26;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_UNDER  = 2'd1;
  localparam status_t ST_OVER   = 2'd2;
  localparam status_t ST_NEGEXP = 2'd3;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

endpackage

[rtl/integer_stack_expression_unit_top.sv]
// ----------------------------------------------------------------------------
// integer_stack_expression_unit_top
// Stack machine expression unit: one opcode per input word on a signed
// integer operand stack held in RAM, with the top entry cached in a register.
//
// Input channel (in_valid/in_ready) carries kind and operand; each accepted
// word gives exactly one result word on the output channel (out_valid/
// out_ready): top_value, depth, take_jump, status, undefined_seen.
// in_ready is high only while the sequencer is idle, one word at a time.
// Simple opcodes pass through the read of the entry below the top, the
// execute step and the result load before the next accept. Multiply,
// divide and modulo run on the shared bit-serial unit. Power uses
// square-and-multiply on the same unit, with the number of multiplies
// set by the exponent's bits.
// The result sits in an output register; while the receiver stalls, the
// sequencer holds in its response step and takes no new word.
// Reset empties the stack and clears the undefined flag; no clearing pass
// over the RAM is needed, as only entries below the depth are used.
// ----------------------------------------------------------------------------
module integer_stack_expression_unit_top #(
  parameter int STACK_DEPTH_MAX = isxu_pkg::STACK_DEPTH_MAX_DEF,
  parameter int VALUE_WIDTH     = isxu_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  isxu_pkg::kind_t                        kind,
  input  logic signed [isxu_pkg::OPERAND_W-1:0]  operand,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [isxu_pkg::TOP_W-1:0]      top_value,
  output logic [isxu_pkg::DEPTH_OUT_W-1:0]       depth,
  output logic                                   take_jump,
  output isxu_pkg::status_t                      status,
  output logic                                   undefined_seen
);

  import isxu_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int AW    = $clog2(STACK_DEPTH_MAX);
  localparam int CNT_W = $clog2(STACK_DEPTH_MAX + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PCHK = 3'd4;
  localparam logic [2:0] S_PMR  = 3'd5;
  localparam logic [2:0] S_PMB  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [W-1:0]     tos, tos_next;
  logic             undef, undef_next;
  logic             jump, jump_next;
  status_t          st, st_next;
  logic [W-1:0]     opa, opa_next;
  logic [W-1:0]     opb, opb_next;
  logic [W-1:0]     pr, pr_next;
  logic [W-1:0]     pbase, pbase_next;
  logic [W-1:0]     pe, pe_next;
  kind_t            kind_q;
  logic [W-1:0]     opnd_q;

  logic             accept;
  logic             resp_load;
  logic             nz;
  logic [AW-1:0]    addr_top;
  logic [AW-1:0]    addr_below;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [W-1:0]     ram_wdata;
  logic             ram_re;
  logic [W-1:0]     ram_rdata;

  mdu_req_t         mreq;
  logic [W-1:0]     m_a;
  logic [W-1:0]     m_b;
  logic             m_done;
  logic [W-1:0]     m_main;
  logic [W-1:0]     m_aux;
  logic [W-1:0]     alu_res;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign nz         = (tos != '0);
  assign addr_top   = AW'(count - CNT_W'(1));
  assign addr_below = AW'(count - CNT_W'(2));

  isxu_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH_MAX)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_below),
    .rdata (ram_rdata)
  );

  isxu_alu #(
    .W (W)
  ) u_alu (
    .kind   (kind_q),
    .a      (ram_rdata),
    .b      (tos),
    .result (alu_res)
  );

  isxu_mdu #(
    .W (W)
  ) u_mdu (
    .clk      (clk),
    .rst      (rst),
    .req      (mreq),
    .a        (m_a),
    .b        (m_b),
    .done     (m_done),
    .main_res (m_main),
    .aux_res  (m_aux)
  );

  always_comb begin
    logic [1:0]   need;
    logic         commit;
    logic         pop;
    logic [W-1:0] r;

    need       = 2'd0;
    commit     = 1'b0;
    pop        = 1'b0;
    r          = '0;
    state_next = state;
    count_next = count;
    tos_next   = tos;
    undef_next = undef;
    jump_next  = jump;
    st_next    = st;
    opa_next   = opa;
    opb_next   = opb;
    pr_next    = pr;
    pbase_next = pbase;
    pe_next    = pe;
    ram_we     = 1'b0;
    ram_waddr  = addr_below;
    ram_wdata  = alu_res;
    ram_re     = 1'b0;
    mreq       = '0;
    m_a        = pbase;
    m_b        = pbase;
    resp_load  = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ram_re     = 1'b1;
          jump_next  = 1'b0;
          st_next    = ST_OK;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        case (kind_q) inside
          K_LNOT, K_BNOT, K_BOOL, K_NEG, K_JUMPZ, K_JUMPNZ, K_JTERN: need = 2'd1;
          [K_LOR:K_BAND], [K_EQ:K_POW]:                               need = 2'd2;
          default:                                                    need = 2'd0;
        endcase
        if (CNT_W'(need) > count) begin
          st_next = ST_UNDER;
        end else begin
          unique case (kind_q) inside
            K_PUSH: begin
              if (count >= CNT_W'(STACK_DEPTH_MAX)) begin
                st_next = ST_OVER;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(count);
                ram_wdata  = opnd_q;
                tos_next   = opnd_q;
                count_next = count + CNT_W'(1);
              end
            end
            K_RESET: count_next = '0;
            K_CLRU:  undef_next = 1'b0;
            K_LNOT, K_BNOT, K_BOOL, K_NEG: begin
              ram_we    = 1'b1;
              ram_waddr = addr_top;
              tos_next  = alu_res;
            end
            [K_LOR:K_BAND], [K_EQ:K_SUB]: begin
              r      = alu_res;
              commit = 1'b1;
            end
            K_MUL: begin
              mreq.start = 1'b1;
              m_a        = ram_rdata;
              m_b        = tos;
              state_next = S_MUL;
            end
            K_DIV, K_MOD: begin
              if (!nz) begin
                r          = '0;
                undef_next = 1'b1;
                commit     = 1'b1;
              end else begin
                opa_next    = ram_rdata;
                opb_next    = tos;
                mreq.start  = 1'b1;
                mreq.is_div = 1'b1;
                m_a         = ram_rdata[W-1] ? ('0 - ram_rdata) : ram_rdata;
                m_b         = tos[W-1] ? ('0 - tos) : tos;
                state_next  = S_DIV;
              end
            end
            K_POW: begin
              if (tos[W-1]) begin
                st_next = ST_NEGEXP;
              end else begin
                pr_next    = W'(1);
                pbase_next = ram_rdata;
                pe_next    = tos;
                state_next = S_PCHK;
              end
            end
            K_JUMPZ: begin
              if (nz) pop = 1'b1;
              else jump_next = 1'b1;
            end
            K_JUMPNZ: begin
              if (nz) jump_next = 1'b1;
              else pop = 1'b1;
            end
            K_JTERN: begin
              pop       = 1'b1;
              jump_next = !nz;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (m_done) begin
          r      = m_main;
          commit = 1'b1;
        end
      end
      S_DIV: begin
        if (m_done) begin
          if (kind_q == K_DIV) begin
            r = (opa[W-1] ^ opb[W-1]) ? ('0 - m_aux) : m_aux;
          end else begin
            r = opa[W-1] ? ('0 - m_main) : m_main;
          end
          commit = 1'b1;
        end
      end
      S_PCHK: begin
        if (pe == '0) begin
          r      = pr;
          commit = 1'b1;
        end else if (pe[0]) begin
          mreq.start = 1'b1;
          m_a        = pr;
          state_next = S_PMR;
        end else begin
          mreq.start = 1'b1;
          state_next = S_PMB;
        end
      end
      S_PMR: begin
        if (m_done) begin
          pr_next = m_main;
          // skip the last squaring once no exponent bits remain
          if (pe[W-1:1] == '0) begin
            pe_next    = '0;
            state_next = S_PCHK;
          end else begin
            mreq.start = 1'b1;
            state_next = S_PMB;
          end
        end
      end
      S_PMB: begin
        if (m_done) begin
          pbase_next = m_main;
          pe_next    = {1'b0, pe[W-1:1]};
          state_next = S_PCHK;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          resp_load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (commit) begin
      ram_we     = 1'b1;
      ram_waddr  = addr_below;
      ram_wdata  = r;
      tos_next   = r;
      count_next = count - CNT_W'(1);
      state_next = S_RESP;
    end
    // the entry below the top was read at accept and becomes the new top
    if (pop) begin
      count_next = count - CNT_W'(1);
      tos_next   = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      undef     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      undef     <= undef_next;
      out_valid <= resp_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    tos   <= tos_next;
    jump  <= jump_next;
    st    <= st_next;
    opa   <= opa_next;
    opb   <= opb_next;
    pr    <= pr_next;
    pbase <= pbase_next;
    pe    <= pe_next;
    if (accept) begin
      kind_q <= kind;
      opnd_q <= W'(operand);
    end
    if (resp_load) begin
      top_value      <= (count != '0) ? TOP_W'($signed(tos)) : '0;
      depth          <= DEPTH_OUT_W'(count);
      take_jump      <= jump;
      status         <= st;
      undefined_seen <= undef;
    end
  end

endmodule

[rtl/isxu_ram.sv]
// ----------------------------------------------------------------------------
// isxu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isxu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/isxu_alu.sv]
// ----------------------------------------------------------------------------
// isxu_alu
// Combinational unary, logic, compare, add and subtract operations.
// Unary operations act on b, the top of stack.
// ----------------------------------------------------------------------------
module isxu_alu #(
  parameter int W = 32
) (
  input  isxu_pkg::kind_t kind,
  input  logic [W-1:0]    a,
  input  logic [W-1:0]    b,
  output logic [W-1:0]    result
);

  import isxu_pkg::*;

  always_comb begin
    unique case (kind) inside
      K_LNOT:  result = W'(b == '0);
      K_BNOT:  result = ~b;
      K_BOOL:  result = W'(b != '0);
      K_NEG:   result = '0 - b;
      K_LOR:   result = W'((a != '0) || (b != '0));
      K_LAND:  result = W'((a != '0) && (b != '0));
      K_BOR:   result = a | b;
      K_XOR:   result = a ^ b;
      K_BAND:  result = a & b;
      K_EQ:    result = W'(a == b);
      K_NE:    result = W'(a != b);
      K_GT:    result = W'($signed(a) > $signed(b));
      K_LT:    result = W'($signed(a) < $signed(b));
      K_GE:    result = W'($signed(a) >= $signed(b));
      K_LE:    result = W'($signed(a) <= $signed(b));
      K_ADD:   result = a + b;
      K_SUB:   result = a - b;
      default: result = '0;
    endcase
  end

endmodule

[rtl/isxu_mdu.sv]
// ----------------------------------------------------------------------------
// isxu_mdu
// Shared iterative unit: shift-add multiply (low W bits) and restoring
// unsigned divide, one bit per cycle.
// ----------------------------------------------------------------------------
module isxu_mdu #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  isxu_pkg::mdu_req_t req,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic               done,
  output logic [W-1:0]       main_res,
  output logic [W-1:0]       aux_res
);

  import isxu_pkg::*;

  localparam int CW = $clog2(W);

  logic          busy;
  logic          is_div;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;  // product, or partial remainder
  logic [W-1:0]  mc;   // multiplicand, or divisor
  logic [W-1:0]  mp;   // multiplier, or dividend / quotient
  logic [W:0]    div_sh;
  logic [W:0]    div_diff;

  assign div_sh   = {acc, mp[W-1]};
  assign div_diff = div_sh - {1'b0, mc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == CW'(W - 1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CW'(W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt    <= '0;
      is_div <= req.is_div;
      acc    <= '0;
      mc     <= req.is_div ? b : a;
      mp     <= req.is_div ? a : b;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (is_div) begin
        // keep the shifted remainder when the divisor does not fit
        if (!div_diff[W]) begin
          acc <= div_diff[W-1:0];
          mp  <= {mp[W-2:0], 1'b1};
        end else begin
          acc <= div_sh[W-1:0];
          mp  <= {mp[W-2:0], 1'b0};
        end
      end else begin
        if (mp[0]) begin
          acc <= acc + mc;
        end
        mc <= {mc[W-2:0], 1'b0};
        mp <= {1'b0, mp[W-1:1]};
      end
    end
  end

  assign main_res = acc;
  assign aux_res  = mp;

endmodule
